// ----- rtl/assert_macros.svh -----
// Assertion macros for the grid sweep generator checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MGSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MGSG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/mgsg_pkg.sv -----
// Shared types and constants of the grid sweep generator.
package mgsg_pkg;

    localparam int VALUE_BITS = 16;
    localparam int POINT_BITS = 10;
    localparam int AXES       = 6;
    // |idx * (end - start)| needs POINT_BITS + VALUE_BITS + 1 bits
    localparam int PROD_BITS  = POINT_BITS + VALUE_BITS + 1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_LOAD  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_GROUP_COUNT = 2'd0,
        CFG_REST_LENGTH = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]                     req_type;
        logic [3:0]                     load_group;
        logic [2:0]                     load_axis;
        logic signed [VALUE_BITS-1:0]   load_start;
        logic signed [VALUE_BITS-1:0]   load_end;
        logic [POINT_BITS-1:0]          load_points;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]   upper_alpha;
        logic signed [VALUE_BITS-1:0]   upper_beta;
        logic signed [VALUE_BITS-1:0]   upper_length;
        logic signed [VALUE_BITS-1:0]   lower_alpha;
        logic signed [VALUE_BITS-1:0]   lower_beta;
        logic signed [VALUE_BITS-1:0]   lower_length;
        logic                           running;
        logic [3:0]                     group_now;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]   start_val;
        logic signed [VALUE_BITS-1:0]   end_val;
        logic [POINT_BITS-1:0]          points;
    } t_entry;

endpackage

// ----- rtl/multi_axis_grid_sweep_generator_unit.sv -----
// Top level of the multi-axis grid sweep generator.
// Loads, start and stop requests finish without leaving idle; an idle or end-of-run tick
// gives the rest pose in the cycle after it is taken. A tick that yields a grid
// point walks the six axes through one table read port, a multiplier and a
// 27-step serial divider; an axis whose count exceeds one goes through the
// divider, an axis with a single point takes its start value, and the odometer
// steps last. The result is shown for one cycle on o_res with o_res_valid
// and cannot be held off; busy drops in that same cycle. Config writes are
// always taken.
module multi_axis_grid_sweep_generator_unit #(
    parameter int MAX_GROUPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  mgsg_pkg::t_in_item  i_in,
    output logic                o_res_valid,
    output mgsg_pkg::t_out_item o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import mgsg_pkg::*;

    localparam int DEPTH = MAX_GROUPS * AXES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = PROD_BITS + 2;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_ABS  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_ACC  = 7'b0100000,
        ST_STEP = 7'b1000000
    } t_state;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    t_state r_state, n_state;
    logic [4:0]  r_gcnt;
    logic [14:0] r_rest;
    logic        r_run, n_run;
    logic        r_gdone, n_gdone;
    logic [3:0]  r_grp, n_grp;
    logic [2:0]  r_axis, n_axis;
    logic [POINT_BITS-1:0] r_idx [AXES];
    logic [POINT_BITS-1:0] n_idx [AXES];
    logic [POINT_BITS-1:0] r_cnt [AXES];
    logic signed [VALUE_BITS-1:0] r_val [AXES];
    logic signed [PROD_BITS-1:0]  r_prod;
    logic                         r_neg;
    logic [POINT_BITS-1:0]        r_den;
    logic signed [VALUE_BITS-1:0] r_sv;
    logic        r_ovalid, n_ovalid;
    t_out_item   r_res, n_res;

    logic        accept, cfg_we, tbl_we, div_go, div_done;
    logic [8:0]  eff;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [POINT_BITS-1:0] cnt_now;
    logic [PROD_BITS-1:0]  quo;
    logic [PROD_BITS-1:0]  mag;
    logic signed [VALUE_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]  prod_c;
    logic signed [SW-1:0]  sum;
    logic signed [VALUE_BITS-1:0] sat_v;
    logic        carry;
    logic [POINT_BITS:0]   inc;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign tbl_we      = accept && (t_req'(i_in.req_type) == REQ_LOAD)
                         && (int'(i_in.load_group) < MAX_GROUPS)
                         && (i_in.load_axis < 3'(AXES));
    assign wr_addr = AW'({5'd0, i_in.load_group} * 9'd6 + {6'd0, i_in.load_axis});
    assign rd_addr = AW'({5'd0, r_grp} * 9'd6 + {6'd0, r_axis});
    assign cnt_now = (r_rd.points == '0) ? POINT_BITS'(1) : r_rd.points;

    always_comb begin
        if (r_gcnt == 5'd0) eff = 9'd1;
        else if (int'(r_gcnt) > MAX_GROUPS) eff = 9'(MAX_GROUPS);
        else eff = {4'd0, r_gcnt};
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_mem[wr_addr] <= '{start_val: i_in.load_start, end_val: i_in.load_end,
                                points: i_in.load_points};
        end
        r_rd <= r_mem[rd_addr];
    end

    // idx * (end - start), both operands at product width
    assign diff   = $signed({r_rd.end_val[VALUE_BITS-1], r_rd.end_val})
                    - $signed({r_rd.start_val[VALUE_BITS-1], r_rd.start_val});
    assign prod_c = $signed({{(PROD_BITS-POINT_BITS){1'b0}}, r_idx[r_axis]})
                    * $signed({{(PROD_BITS-VALUE_BITS-1){diff[VALUE_BITS]}}, diff});
    assign mag    = r_prod[PROD_BITS-1] ? PROD_BITS'(-r_prod) : PROD_BITS'(r_prod);

    mgsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (mag),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quo      (quo)
    );

    assign div_go = (r_state == ST_ABS);
    assign sum    = SW'(r_sv) + (r_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));

    always_comb begin
        if (sum > SW'((1 <<< (VALUE_BITS-1)) - 1))
            sat_v = VALUE_BITS'((1 <<< (VALUE_BITS-1)) - 1);
        else if (sum < -SW'(1 <<< (VALUE_BITS-1)))
            sat_v = VALUE_BITS'(-(1 <<< (VALUE_BITS-1)));
        else
            sat_v = sum[VALUE_BITS-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_run    = r_run;
        n_gdone  = r_gdone;
        n_grp    = r_grp;
        n_axis   = r_axis;
        n_ovalid = 1'b0;
        n_res    = r_res;
        carry    = 1'b1;
        inc      = '0;
        for (int a = 0; a < AXES; a++) n_idx[a] = r_idx[a];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_in.req_type))
                        REQ_START: n_run = 1'b1;
                        REQ_STOP:  n_run = 1'b0;
                        REQ_LOAD:  ;
                        REQ_TICK: begin
                            // rest pose unless a point is due
                            n_res = '{upper_alpha: '0, upper_beta: '0,
                                      upper_length: {1'b0, r_rest},
                                      lower_alpha: '0, lower_beta: '0,
                                      lower_length: {1'b0, r_rest},
                                      running: 1'b0, group_now: r_grp};
                            priority if (!r_run) begin
                                for (int a = 0; a < AXES; a++) n_idx[a] = '0;
                                n_gdone  = 1'b0;
                                n_ovalid = 1'b1;
                            end else if ({5'd0, r_grp} >= eff) begin
                                n_run = 1'b0;
                                for (int a = 0; a < AXES; a++) n_idx[a] = '0;
                                n_gdone  = 1'b0;
                                n_ovalid = 1'b1;
                            end else if (r_gdone && ({5'd0, r_grp} + 9'd1 >= eff)) begin
                                n_run = 1'b0;
                                for (int a = 0; a < AXES; a++) n_idx[a] = '0;
                                n_gdone  = 1'b0;
                                n_ovalid = 1'b1;
                            end else begin
                                if (r_gdone) begin
                                    n_grp = r_grp + 4'd1;
                                    for (int a = 0; a < AXES; a++) n_idx[a] = '0;
                                    n_gdone = 1'b0;
                                end
                                n_axis  = '0;
                                n_state = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL: begin
                if (cnt_now == POINT_BITS'(1)) begin
                    if (r_axis == 3'(AXES-1)) begin
                        n_state = ST_STEP;
                    end else begin
                        n_axis  = r_axis + 3'd1;
                        n_state = ST_READ;
                    end
                end else begin
                    n_state = ST_ABS;
                end
            end
            ST_ABS: n_state = ST_DIV;
            ST_DIV: if (div_done) n_state = ST_ACC;
            ST_ACC: begin
                if (r_axis == 3'(AXES-1)) begin
                    n_state = ST_STEP;
                end else begin
                    n_axis  = r_axis + 3'd1;
                    n_state = ST_READ;
                end
            end
            ST_STEP: begin
                n_res = '{upper_alpha: r_val[0], upper_beta: r_val[1],
                          upper_length: r_val[2], lower_alpha: r_val[3],
                          lower_beta: r_val[4], lower_length: r_val[5],
                          running: 1'b1, group_now: r_grp};
                n_ovalid = 1'b1;
                // odometer, axis 0 fastest
                for (int a = 0; a < AXES; a++) begin
                    inc = {1'b0, r_idx[a]} + (POINT_BITS+1)'(1);
                    if (carry) begin
                        if (inc >= {1'b0, r_cnt[a]}) begin
                            n_idx[a] = '0;
                        end else begin
                            n_idx[a] = inc[POINT_BITS-1:0];
                            carry    = 1'b0;
                        end
                    end
                end
                if (carry) n_gdone = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_gcnt   <= 5'd1;
            r_rest   <= 15'd676;
            r_run    <= 1'b0;
            r_gdone  <= 1'b0;
            r_grp    <= '0;
            r_axis   <= '0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < AXES; a++) r_idx[a] <= '0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_gdone  <= n_gdone;
            r_grp    <= n_grp;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
            for (int a = 0; a < AXES; a++) r_idx[a] <= n_idx[a];
            if (cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_GROUP_COUNT))
                r_gcnt <= i_cfg_data[4:0];
            if (cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_REST_LENGTH))
                r_rest <= i_cfg_data[14:0];
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == ST_MUL) begin
            r_cnt[r_axis] <= cnt_now;
            r_sv          <= r_rd.start_val;
            r_den         <= cnt_now - POINT_BITS'(1);
            r_prod        <= prod_c;
            if (cnt_now == POINT_BITS'(1)) r_val[r_axis] <= r_rd.start_val;
        end
        if (r_state == ST_ABS) r_neg <= r_prod[PROD_BITS-1];
        if (r_state == ST_ACC) r_val[r_axis] <= sat_v;
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

// ----- rtl/mgsg_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module mgsg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [mgsg_pkg::PROD_BITS-1:0] i_dividend,
    input  logic [mgsg_pkg::POINT_BITS-1:0] i_divisor,
    output logic                           o_done,
    output logic [mgsg_pkg::PROD_BITS-1:0] o_quo
);
    import mgsg_pkg::*;

    localparam int CW = $clog2(PROD_BITS + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [POINT_BITS-1:0] r_rem, n_rem;
    logic [POINT_BITS-1:0] r_den, n_den;
    logic [PROD_BITS-1:0]  r_quo, n_quo;
    logic [POINT_BITS:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[PROD_BITS-1]};
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = CW'(PROD_BITS);
            n_rem  = '0;
            n_den  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = POINT_BITS'(trial - {1'b0, r_den});
                n_quo = {r_quo[PROD_BITS-2:0], 1'b1};
            end else begin
                n_rem = trial[POINT_BITS-1:0];
                n_quo = {r_quo[PROD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/mgsg_chk.sv -----
// Port-level checker for the grid sweep generator, bound to the top level.
`include "assert_macros.svh"

module mgsg_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input mgsg_pkg::t_in_item  i_in,
    input logic                o_res_valid,
    input mgsg_pkg::t_out_item o_res
);
    import mgsg_pkg::*;

    `MGSG_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!o_busy && !o_res_valid), "not quiet after reset")
    `MGSG_ASSERT(a_strobe_idle, o_res_valid |-> !o_busy, "result while busy")
    `MGSG_ASSERT(a_no_result_other, (i_start && !o_busy && (i_in.req_type != REQ_TICK)) |=> !o_res_valid, "result for non-tick transfer")
    `MGSG_ASSERT(a_rest_pose, (o_res_valid && !o_res.running) |-> (o_res.upper_alpha == '0 && o_res.lower_beta == '0 && o_res.upper_length == o_res.lower_length), "bad rest pose")

endmodule

bind multi_axis_grid_sweep_generator_unit mgsg_chk u_mgsg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_in        (i_in),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
